// ===== rtl/core/sha1s_pkg.sv =====
package sha1s_pkg;

  // One 512-bit message block, word 0 holds the first four bytes (big-endian).
  typedef logic [15:0][31:0] block_t;

  // A block handed from the packer to the compression engine.
  typedef struct packed {
    logic   last_blk;   // digest is delivered after this block
    block_t data;
  } job_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

endpackage

// ===== rtl/core/sha1s_front.sv =====
module sha1s_front import sha1s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_job
);

  localparam logic [2:0] F_FILL       = 3'd0;
  localparam logic [2:0] F_PUSH_DATA  = 3'd1;
  localparam logic [2:0] F_PAD        = 3'd2;
  localparam logic [2:0] F_PUSH_PAD   = 3'd3;
  localparam logic [2:0] F_PUSH_FINAL = 3'd4;

  logic [2:0]  state;
  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic        last_pending;
  block_t      blk;
  logic        accept;

  assign s_tready = (state == F_FILL);
  assign accept   = s_tvalid && s_tready;

  assign push_valid = (state == F_PUSH_DATA) || (state == F_PUSH_PAD) ||
                      (state == F_PUSH_FINAL);
  assign push_job.last_blk = (state == F_PUSH_FINAL);
  assign push_job.data     = blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_FILL;
      pos          <= '0;
      bit_len      <= '0;
      last_pending <= 1'b0;
    end else begin
      case (state)
        F_FILL: begin
          if (accept) begin
            if (s_tuser) begin
              pos     <= pos + 6'd1;
              bit_len <= bit_len + 64'd8;
              if (pos == 6'd63) begin
                state        <= F_PUSH_DATA;
                last_pending <= s_tlast;
              end else if (s_tlast) begin
                state <= F_PAD;
              end
            end else if (s_tlast) begin
              state <= F_PAD;
            end
          end
        end
        F_PUSH_DATA: begin
          if (push_ready) begin
            state <= last_pending ? F_PAD : F_FILL;
          end
        end
        F_PAD: begin
          state <= (pos >= 6'd56) ? F_PUSH_PAD : F_PUSH_FINAL;
        end
        F_PUSH_PAD: begin
          if (push_ready) begin
            state <= F_PUSH_FINAL;
          end
        end
        F_PUSH_FINAL: begin
          if (push_ready) begin
            state   <= F_FILL;
            pos     <= '0;
            bit_len <= '0;
          end
        end
        default: begin
          state <= F_FILL;
        end
      endcase
    end
  end

  // Byte storage: one byte per transfer, padding and length written in bulk.
  always_ff @(posedge clk) begin
    if (state == F_FILL && accept && s_tuser) begin
      blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= s_tdata;
    end else if (state == F_PAD) begin
      for (int q = 0; q < 64; q++) begin
        if (q >= 56 && pos < 6'd56) begin
          blk[q >> 2][8*(3 - (q & 3)) +: 8] <= bit_len[8*(63 - q) +: 8];
        end else if (6'(q) == pos) begin
          blk[q >> 2][8*(3 - (q & 3)) +: 8] <= PAD_BYTE;
        end else if (6'(q) > pos) begin
          blk[q >> 2][8*(3 - (q & 3)) +: 8] <= 8'h00;
        end
      end
    end else if (state == F_PUSH_PAD && push_ready) begin
      for (int w = 0; w < 14; w++) begin
        blk[w] <= 32'h0;
      end
      blk[14] <= bit_len[63:32];
      blk[15] <= bit_len[31:0];
    end
  end

endmodule

// ===== rtl/core/sha1s_queue.sv =====
module sha1s_queue import sha1s_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/sha1s_engine.sv =====
module sha1s_engine import sha1s_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  job_t        pop_job,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_ROUND = 2'd1;
  localparam logic [1:0] E_ADD   = 2'd2;
  localparam logic [1:0] E_OUT   = 2'd3;

  logic [1:0]        state;
  logic [6:0]        round;
  logic [31:0]       a, b, c, d, e;
  logic [15:0][31:0] win;
  logic [31:0]       chain [5];
  logic              is_last;
  logic [2:0]        out_idx;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] w_mix;

  assign pop_ready = (state == E_IDLE);

  assign m_tvalid = (state == E_OUT);
  assign m_tdata  = chain[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == LAST_WORD_IDX);

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t     = {a[26:0], a[31:27]} + f + e + k + win[0];
    w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        win <= pop_job.data;
        a   <= chain[0];
        b   <= chain[1];
        c   <= chain[2];
        d   <= chain[3];
        e   <= chain[4];
      end
      E_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i+1];
        end
        win[15] <= {w_mix[30:0], w_mix[31]};
        a <= t;
        b <= a;
        c <= {b[1:0], b[31:2]};
        d <= c;
        e <= d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      round    <= '0;
      is_last  <= 1'b0;
      out_idx  <= '0;
      chain[0] <= IV0;
      chain[1] <= IV1;
      chain[2] <= IV2;
      chain[3] <= IV3;
      chain[4] <= IV4;
    end else begin
      case (state)
        E_IDLE: begin
          if (pop_valid) begin
            state   <= E_ROUND;
            round   <= '0;
            is_last <= pop_job.last_blk;
          end
        end
        E_ROUND: begin
          round <= round + 7'd1;
          if (round == LAST_ROUND) begin
            state <= E_ADD;
          end
        end
        E_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          out_idx  <= '0;
          state    <= is_last ? E_OUT : E_IDLE;
        end
        E_OUT: begin
          if (m_tready) begin
            if (out_idx == LAST_WORD_IDX) begin
              state    <= E_IDLE;
              out_idx  <= '0;
              chain[0] <= IV0;
              chain[1] <= IV1;
              chain[2] <= IV2;
              chain[3] <= IV3;
              chain[4] <= IV4;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
// Throughput: one byte transfer per cycle while a block fills; the input stalls after each
// full block until it is queued, and the compression engine, which takes no new block until
// it is done with the last one, bounds the rate. After the closing transfer the front pads
// the block (and one more if the length does not fit); the engine compresses them behind
// any queued block, then gives five digest words, one per cycle while the receiver is ready.
// Reset (rst, synchronous, active high) restores the initial hash and empties all control.

module sha1_stream_hasher import sha1s_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream: one message byte per transfer.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] msg_byte
  input  wire logic        s_tuser,  // [0] byte_valid
  input  wire logic        s_tlast,  // last_byte: ends the message
  // Output stream: five digest words per message, most significant first.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,  // [31:0] digest_word
  output      logic [2:0]  m_tuser,  // [2:0] word_index
  output      logic        m_tlast   // last_word
);

  // The front packs bytes into a 64-byte block and appends the padding and the
  // 64-bit bit length. Finished blocks wait in a two-entry queue, so the front
  // keeps taking bytes while the engine compresses the previous block.
  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  sha1s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  sha1s_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  // The engine chains each block into the running hash. After the block that
  // closes a message it presents the digest straight from the hash registers,
  // one word per transfer, then reloads the initial hash.
  sha1s_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/sv/tb_sha1_stream_hasher.sv =====
`timescale 1ns / 1ps

module tb_sha1_stream_hasher;

  // Hash state restored at reset and after every digest.
  localparam logic [31:0] INIT_HASH [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [7:0] PAD_MARK       = 8'h80;
  localparam logic [2:0] FINAL_WORD_IDX = 3'd4;

  // Well-known digests used to anchor the directed rows.
  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  localparam int QUIET_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int DRAIN_WAIT  = 200;   // extra wait for any stray word after the last expected one

  // Message lengths around the padding and block boundaries.
  localparam int EDGE_LENS [6] = '{55, 56, 57, 63, 64, 65};

  typedef struct packed {
    logic         data_ok;    // byte_valid
    logic [7:0]   value;      // msg_byte
    logic         closes;     // last_byte
    logic         has_known;  // digest below is typed in
    logic [159:0] known;
  } dir_row_t;

  localparam int DIR_ROWS_N = 13;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{1'b0, 8'h00, 1'b0, 1'b0, 160'h0},          // idle item, no effect
    '{1'b0, 8'hFF, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message
    '{1'b1, 8'h61, 1'b0, 1'b0, 160'h0},          // "a"
    '{1'b0, 8'hA5, 1'b0, 1'b0, 160'h0},          // idle with junk data
    '{1'b1, 8'h62, 1'b0, 1'b0, 160'h0},          // "b"
    '{1'b1, 8'h63, 1'b1, 1'b1, ABC_DIGEST},      // "c" closes "abc"
    '{1'b1, 8'h00, 1'b1, 1'b0, 160'h0},          // single zero byte
    '{1'b1, 8'hFF, 1'b0, 1'b0, 160'h0},
    '{1'b1, 8'h00, 1'b0, 1'b0, 160'h0},
    '{1'b0, 8'h5A, 1'b1, 1'b0, 160'h0},          // data-less end mid-block
    '{1'b0, 8'h00, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message back to back
    '{1'b1, 8'h80, 1'b1, 1'b0, 160'h0},          // byte equal to the pad mark
    '{1'b1, 8'h7F, 1'b1, 1'b0, 160'h0}
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] msg_byte
  logic        s_tuser;   // [0] byte_valid
  logic        s_tlast;   // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] digest_word
  logic [2:0]  m_tuser;   // [2:0] word_index
  logic        m_tlast;   // last_word

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  digest_out_t pending_digest[$];

  // Independent SHA-1 state used to predict every digest.
  logic [31:0] run_hash [5];
  logic [31:0] blk_words [16];
  int          fill_pos;
  logic [63:0] msg_bits;
  logic [31:0] digest_words [5];

  sha1_stream_hasher u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 5; i++) run_hash[i] = INIT_HASH[i];
    fill_pos = 0;
    msg_bits = 64'd0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++) w[r] = blk_words[r];
    for (r = 16; r < 80; r++) w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = run_hash[0]; b = run_hash[1]; c = run_hash[2]; d = run_hash[3]; e = run_hash[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
      end else if (r < 40 || r >= 60) begin
        f = b ^ c ^ d;
      end else begin
        f = (b & c) | (b & d) | (c & d);
      end
      k = ROUND_K[r / 20];
      t = rotl(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    run_hash[0] += a; run_hash[1] += b; run_hash[2] += c;
    run_hash[3] += d; run_hash[4] += e;
  endfunction

  // Bytes land big-endian; the first byte of a word clears it.
  function automatic void place_byte(input int pos, input logic [7:0] v);
    int wi;
    int sh;
    wi = (pos >> 2) & 15;
    sh = 8 * (3 - (pos & 3));
    if ((pos & 3) == 0) blk_words[wi] = 32'h0;
    blk_words[wi][sh +: 8] = v;
  endfunction

  // Returns 1 when the item closes a message; the digest is left in digest_words.
  function automatic bit hash_item(input logic data_ok, input logic [7:0] v,
                                   input logic closes);
    int p;
    int q;
    if (data_ok) begin
      place_byte(fill_pos, v);
      msg_bits += 64'd8;
      fill_pos = (fill_pos + 1) & 63;
      if (fill_pos == 0) sha1_compress();
    end
    if (!closes) return 1'b0;
    p = fill_pos;
    place_byte(p, PAD_MARK);
    for (q = p + 1; q < 64; q++) place_byte(q, 8'h00);
    // No room left for the length: it goes into an extra block.
    if (p >= 56) begin
      sha1_compress();
      for (q = 0; q < 16; q++) blk_words[q] = 32'h0;
    end
    blk_words[14] = msg_bits[63:32];
    blk_words[15] = msg_bits[31:0];
    sha1_compress();
    for (q = 0; q < 5; q++) digest_words[q] = run_hash[q];
    restart_hash();
    return 1'b1;
  endfunction

  // Drives one input item, waits for its transfer, and records what it should produce.
  task automatic send_item(input logic data_ok, input logic [7:0] v, input logic closes,
                           input logic has_known, input logic [159:0] known);
    int i;
    digest_out_t item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      s_tuser  = 1'($urandom);
      s_tlast  = 1'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    s_tuser  = data_ok;
    s_tlast  = closes;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (hash_item(data_ok, v, closes)) begin
      for (i = 0; i < 5; i++) begin
        item.word = has_known ? known[159 - 32*i -: 32] : digest_words[i];
        item.idx  = 3'(i);
        item.last = (3'(i) == FINAL_WORD_IDX);
        pending_digest.push_back(item);
      end
    end
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, want, got);
  endtask

  // The receiver stalls at random; the rate follows the current phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every digest transfer is checked field by field against the oldest prediction.
  always @(posedge clk) begin
    digest_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("unexpected digest_word", 32'h0, m_tdata);
      end else begin
        want = pending_digest.pop_front();
        if (m_tdata !== want.word) report_mismatch("digest_word", want.word, m_tdata);
        if (m_tuser !== want.idx) report_mismatch("word_index", 32'(want.idx), 32'(m_tuser));
        if (m_tlast !== want.last) report_mismatch("last_word", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  // A run that stops moving on both sides ends here.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int row;
    int phase;
    int len;
    int i;
    int phase_items;
    int phase_msgs;
    int pick;
    bit data_end;

    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    rst      = 1'b1;
    restart_hash();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed rows, run with no idling on either side.
    for (row = 0; row < DIR_ROWS_N; row++)
      send_item(DIR_ROWS[row].data_ok, DIR_ROWS[row].value, DIR_ROWS[row].closes,
                DIR_ROWS[row].has_known, DIR_ROWS[row].known);

    // Random messages: mostly short, with a share of lengths that sit on the
    // padding edge (55/56 bytes) and on whole blocks. Idle items are mixed in as noise.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      phase_items = 0;
      phase_msgs  = 0;
      while (phase_items < 12 || phase_msgs < 2) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 8);
        else if (pick < 85) len = $urandom_range(9, 30);
        else len = EDGE_LENS[$urandom_range(0, 5)];
        data_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(1'b0, 8'($urandom), 1'b0, 1'b0, 160'h0);
            phase_items++;
          end
          send_item(1'b1, 8'($urandom), data_end && (i == len - 1), 1'b0, 160'h0);
        end
        if (!data_end) send_item(1'b0, 8'($urandom), 1'b1, 1'b0, 160'h0);
        phase_items += len + (data_end ? 0 : 1);
        phase_msgs++;
      end
    end

    s_tvalid = 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    // Any word that shows up late is still caught by the checker.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_digest.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
